// File: src/keyed_record_table_compacting_top_macros.svh
// Assertion macros shared by the record table RTL.
// Depends on the including module providing signals named clock and reset.
`ifndef KEYED_RECORD_TABLE_COMPACTING_TOP_MACROS_SVH
`define KEYED_RECORD_TABLE_COMPACTING_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KRTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KRTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/krtc_pkg.sv
// Types, codes and the control store for the record table sequencer.
// Self-contained; used by keyed_record_table_compacting_top.
package krtc_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int INDEX_W   = 6;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Program steps of the sequencer.
   typedef enum logic [4:0] {
      STEP_IDLE      = 5'd0,
      STEP_DISPATCH  = 5'd1,
      STEP_CHK_EMPTY = 5'd2,
      STEP_FIRST_RD  = 5'd3,
      STEP_SRCH_CMP  = 5'd4,
      STEP_SRCH_NEXT = 5'd5,
      STEP_ERR_NF    = 5'd6,
      STEP_FOUND     = 5'd7,
      STEP_SHIFT_CHK = 5'd8,
      STEP_SHIFT_WR  = 5'd9,
      STEP_DEL_END   = 5'd10,
      STEP_DUMP      = 5'd11,
      STEP_DUMP_END  = 5'd12,
      STEP_ADD       = 5'd13,
      STEP_ADD_WR    = 5'd14,
      STEP_ERR_FULL  = 5'd15,
      STEP_ERR_EMPTY = 5'd16
   } step_type;

   // Jump conditions; a true condition loads the target, else the step counter advances.
   typedef enum logic [3:0] {
      COND_ALWAYS   = 4'd0,
      COND_NSTART   = 4'd1,
      COND_CMD_ADD  = 4'd2,
      COND_CMD_DUMP = 4'd3,
      COND_NOT_DEL  = 4'd4,
      COND_EMPTY    = 4'd5,
      COND_FULL     = 4'd6,
      COND_MATCH    = 4'd7,
      COND_LAST     = 4'd8,
      COND_NOT_LAST = 4'd9
   } cond_type;

   // Record RAM write source.
   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_REQ   = 2'd1,
      WR_SHIFT = 2'd2
   } wr_type;

   // Response source.
   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_REQ  = 2'd1,
      EMIT_RAM  = 2'd2,
      EMIT_ERR  = 2'd3
   } emit_type;

   // One control word.
   typedef struct packed {
      cond_type   cond;
      step_type   target;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_next;
      wr_type     wr_sel;
      emit_type   emit;
      status_type status;
      logic       last_at_end;
      logic       cnt_inc;
      logic       cnt_dec;
   } ctrl_type;

   // Control store: one word per program step.
   function automatic ctrl_type ucode_rom(input step_type step);
      ctrl_type w;
      w.cond        = COND_ALWAYS;
      w.target      = STEP_IDLE;
      w.idx_clr     = 1'b0;
      w.idx_inc     = 1'b0;
      w.rd_next     = 1'b0;
      w.wr_sel      = WR_NONE;
      w.emit        = EMIT_NONE;
      w.status      = ST_OK;
      w.last_at_end = 1'b0;
      w.cnt_inc     = 1'b0;
      w.cnt_dec     = 1'b0;
      unique case (step)
         STEP_IDLE: begin
            w.cond   = COND_NSTART;
            w.target = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.cond   = COND_CMD_ADD;
            w.target = STEP_ADD;
         end
         STEP_CHK_EMPTY: begin
            w.cond    = COND_EMPTY;
            w.target  = STEP_ERR_EMPTY;
            w.idx_clr = 1'b1;
         end
         STEP_FIRST_RD: begin
            w.cond   = COND_CMD_DUMP;
            w.target = STEP_DUMP;
         end
         STEP_SRCH_CMP: begin
            w.cond   = COND_MATCH;
            w.target = STEP_FOUND;
         end
         STEP_SRCH_NEXT: begin
            w.cond    = COND_NOT_LAST;
            w.target  = STEP_SRCH_CMP;
            w.idx_inc = 1'b1;
            w.rd_next = 1'b1;
         end
         STEP_ERR_NF: begin
            w.emit   = EMIT_ERR;
            w.status = ST_NOTFOUND;
         end
         STEP_FOUND: begin
            w.cond   = COND_NOT_DEL;
            w.target = STEP_IDLE;
            w.emit   = EMIT_RAM;
         end
         STEP_SHIFT_CHK: begin
            w.cond    = COND_LAST;
            w.target  = STEP_DEL_END;
            w.rd_next = 1'b1;
         end
         STEP_SHIFT_WR: begin
            w.target  = STEP_SHIFT_CHK;
            w.wr_sel  = WR_SHIFT;
            w.idx_inc = 1'b1;
         end
         STEP_DEL_END: begin
            w.cnt_dec = 1'b1;
         end
         STEP_DUMP: begin
            w.cond        = COND_NOT_LAST;
            w.target      = STEP_DUMP;
            w.emit        = EMIT_RAM;
            w.last_at_end = 1'b1;
            w.idx_inc     = 1'b1;
            w.rd_next     = 1'b1;
         end
         STEP_DUMP_END: begin
            w.target = STEP_IDLE;
         end
         STEP_ADD: begin
            w.cond   = COND_FULL;
            w.target = STEP_ERR_FULL;
         end
         STEP_ADD_WR: begin
            w.wr_sel  = WR_REQ;
            w.emit    = EMIT_REQ;
            w.cnt_inc = 1'b1;
         end
         STEP_ERR_FULL: begin
            w.emit   = EMIT_ERR;
            w.status = ST_FULL;
         end
         STEP_ERR_EMPTY: begin
            w.emit   = EMIT_ERR;
            w.status = ST_EMPTY;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: src/krtc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module krtc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: src/keyed_record_table_compacting_top.sv
// Record table: up to DEPTH keyed records in insertion order, run by a microcoded sequencer.
// Depends on krtc_pkg, krtc_ram and keyed_record_table_compacting_top_macros.svh.
//
// A request is taken when start is high and busy is low; busy stays high until the whole
// command is done. Every record lives in one RAM with a single read port whose data is
// registered and comes in the cycle after the address. A search walks the table with a
// compare step and an advance step per entry; a delete that matches then moves each later
// record down with a check step and a write step; a dump emits one entry at each step. A
// new request can be taken in the first cycle with busy low. Each response is registered
// and appears in the cycle after the program step that forms it: a dump gives one response
// per cycle, the final one flagged by rsp_last, and a search, delete or dump on an empty
// table gives a single empty-status response. Responses are rsp_valid strobes of one cycle;
// the receiver cannot stall them, so it must take each one as it appears.
`include "keyed_record_table_compacting_top_macros.svh"

module keyed_record_table_compacting_top #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic signed [31:0] req_key,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_entry_index,
   output logic signed [31:0] rsp_entry_key,
   output logic [63:0] rsp_entry_payload,
   output logic        rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = krtc_pkg::KEY_W + krtc_pkg::PAYLOAD_W;

   // Sequencer
   krtc_pkg::step_type step_ff, step_in;
   krtc_pkg::ctrl_type word;
   logic               cond_true;

   // Request held for the duration of the command
   krtc_pkg::cmd_type             cmd_ff;
   logic [krtc_pkg::KEY_W-1:0]     key_ff;
   logic [krtc_pkg::PAYLOAD_W-1:0] payload_ff;
   logic                          accept;

   // Datapath
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          at_end;

   // Record RAM
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] rd_data;
   logic [krtc_pkg::KEY_W-1:0]     rd_key;
   logic [krtc_pkg::PAYLOAD_W-1:0] rd_payload;

   // Response registers
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [krtc_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [krtc_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [krtc_pkg::PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Fetch the control word for the current step.
   assign word   = krtc_pkg::ucode_rom(step_ff);
   assign busy   = (step_ff != krtc_pkg::STEP_IDLE);
   assign accept = start && !busy;

   assign rd_key     = rd_data[RW-1 -: krtc_pkg::KEY_W];
   assign rd_payload = rd_data[krtc_pkg::PAYLOAD_W-1:0];

   // The current index is the final live entry.
   assign at_end = (CW'(idx_ff) + CW'(1)) >= count_ff;

   // Evaluate the jump condition.
   always_comb begin
      unique case (word.cond)
         krtc_pkg::COND_ALWAYS:   cond_true = 1'b1;
         krtc_pkg::COND_NSTART:   cond_true = !start;
         krtc_pkg::COND_CMD_ADD:  cond_true = (cmd_ff == krtc_pkg::CMD_ADD);
         krtc_pkg::COND_CMD_DUMP: cond_true = (cmd_ff == krtc_pkg::CMD_DUMP);
         krtc_pkg::COND_NOT_DEL:  cond_true = (cmd_ff != krtc_pkg::CMD_DELETE);
         krtc_pkg::COND_EMPTY:    cond_true = (count_ff == CW'(0));
         krtc_pkg::COND_FULL:     cond_true = (count_ff == CW'(DEPTH));
         krtc_pkg::COND_MATCH:    cond_true = (rd_key == key_ff);
         krtc_pkg::COND_LAST:     cond_true = at_end;
         krtc_pkg::COND_NOT_LAST: cond_true = !at_end;
         default:                 cond_true = 1'b1;
      endcase
   end

   // Next step: jump on a true condition, else fall through.
   always_comb begin
      if (cond_true) begin
         step_in = word.target;
      end else begin
         step_in = krtc_pkg::step_type'(5'(step_ff) + 5'd1);
      end
   end

   // Index pointer and entry count.
   always_comb begin
      priority if (word.idx_clr) begin
         idx_in = '0;
      end else if (word.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end else begin
         idx_in = idx_ff;
      end
      priority if (word.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (word.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // RAM addressing: append at the count, move a record down at the index.
   always_comb begin
      rd_addr = word.rd_next ? (idx_ff + AW'(1)) : idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      unique case (word.wr_sel)
         krtc_pkg::WR_REQ: begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_ff);
            wr_data = {key_ff, payload_ff};
         end
         krtc_pkg::WR_SHIFT: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Build the response for this step.
   always_comb begin
      rsp_valid_in   = (word.emit != krtc_pkg::EMIT_NONE);
      rsp_status_in  = word.status;
      rsp_last_in    = word.last_at_end ? at_end : 1'b1;
      rsp_index_in   = '0;
      rsp_key_in     = '0;
      rsp_payload_in = '0;
      unique case (word.emit)
         krtc_pkg::EMIT_REQ: begin
            rsp_index_in   = krtc_pkg::INDEX_W'(count_ff);
            rsp_key_in     = key_ff;
            rsp_payload_in = payload_ff;
         end
         krtc_pkg::EMIT_RAM: begin
            rsp_index_in   = krtc_pkg::INDEX_W'(idx_ff);
            rsp_key_in     = rd_key;
            rsp_payload_in = rd_payload;
         end
         default: begin
            rsp_index_in = '0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= krtc_pkg::STEP_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         cmd_ff     <= krtc_pkg::cmd_type'(req_cmd);
         key_ff     <= req_key;
         payload_ff <= req_payload;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_last_ff    <= rsp_last_in;
   end

   krtc_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_entry_key     = rsp_key_ff;
   assign rsp_entry_payload = rsp_payload_ff;
   assign rsp_last          = rsp_last_ff;

   // The entry count never passes the table size.
   `KRTC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "entry count beyond table size")

   // A response only follows a cycle in which a command was running.
   `KRTC_ASSERT_NOW(a_rsp_from_busy, rsp_valid_ff, $past(step_ff) != krtc_pkg::STEP_IDLE, "response without command")

   // An accepted request keeps the block busy in the next cycle.
   `KRTC_ASSERT_NEXT(a_accept_busy, accept, busy, "request accepted but sequencer idle")

   // Records are only written while a command runs.
   `KRTC_ASSERT_NOW(a_wr_busy, wr_en, busy, "record write while idle")

endmodule
